FILE: hdl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants for the two-way transposition table.
// ----------------------------------------------------------------------------
package ttt_pkg;

    // Field widths of one request and one result.
    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int AGE_W   = 16;
    localparam int SCORE_W = 32;
    localparam int MOVE_W  = 16;
    localparam int FUNC_W  = 2;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Reset value of the age tolerance register.
    localparam logic [AGE_W-1:0] AGE_TOL_RESET = 16'd4;

    // One slot of either way.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [AGE_W-1:0]   age;
        logic [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]  move;
        logic [DEPTH_W-1:0] depth;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted request
        logic wipe;      // zero one slot of both ways at the sweep address
        logic read;      // read both ways at the computed index
        logic commit;    // perform the store write, if the request is a store
        logic out_load;  // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wipe_last; // the sweep address is the last slot
        logic idx_done;  // the slot index is ready
    } t_sts;

endpackage

FILE: hdl/ttt_mod.sv
// ----------------------------------------------------------------------------
// ttt_mod
// Slot index unit: key modulo ENTRIES. A power-of-two table registers the low
// key bits. Any other size folds in one key byte per cycle, most significant
// first, through a 256-entry residue table, and raises o_done after the last
// byte.
// ----------------------------------------------------------------------------
module ttt_mod
    import ttt_pkg::*;
#(
    parameter int ENTRIES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [KEY_W-1:0]           i_key,
    output logic                       o_done,
    output logic [$clog2(ENTRIES)-1:0] o_idx
);

    localparam int IDX_W = $clog2(ENTRIES);

    generate
        if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
            logic             r_done;
            logic [IDX_W-1:0] r_idx;

            // The index is simply the low bits of the key.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_idx <= i_key[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_idx  = r_idx;
        end else begin : g_fold
            localparam int STEPS = KEY_W / 8;
            localparam int CNT_W = $clog2(STEPS + 1);
            localparam logic [IDX_W+1:0] ENT_C  = (IDX_W + 2)'(ENTRIES);
            localparam logic [IDX_W+1:0] ENT2_C = (IDX_W + 2)'(2 * ENTRIES);

            logic                    r_done;
            logic [CNT_W-1:0]        r_cnt;
            logic [KEY_W-1:0]        r_shift;
            logic [IDX_W-1:0]        r_rem;
            logic [255:0][IDX_W-1:0] fold_tbl;
            logic [IDX_W+7:0]        joined;
            logic [IDX_W+1:0]        folded;
            logic [IDX_W+1:0]        reduced;

            // Residue of v * 2^IDX_W for every byte value v above the index bits.
            for (genvar v = 0; v < 256; v++) begin : g_tbl
                localparam logic [IDX_W-1:0] FOLD_C =
                    IDX_W'((longint'(v) << IDX_W) % longint'(ENTRIES));
                assign fold_tbl[v] = FOLD_C;
            end

            // One step: append the next key byte, fold the byte that overflows
            // the index width back in, then bring the sum below ENTRIES.
            assign joined  = {r_rem, r_shift[KEY_W-1 -: 8]};
            assign folded  = (IDX_W + 2)'(fold_tbl[joined[IDX_W+7:IDX_W]]) +
                             (IDX_W + 2)'(joined[IDX_W-1:0]);
            assign reduced = (folded >= ENT2_C) ? (folded - ENT2_C) :
                             (folded >= ENT_C)  ? (folded - ENT_C)  : folded;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else if (i_start) begin
                    r_done <= 1'b0;
                    r_cnt  <= CNT_W'(STEPS);
                end else if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_done <= 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_shift <= i_key;
                    r_rem   <= '0;
                end else if (r_cnt != '0) begin
                    r_shift <= {r_shift[KEY_W-9:0], 8'd0};
                    r_rem   <= reduced[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_idx  = r_rem;
        end
    endgenerate

endmodule

FILE: hdl/ttt_datapath.sv
// ----------------------------------------------------------------------------
// ttt_datapath
// Request registers, the two way memories, the replacement decision, the
// lookup compare, the age tolerance register and the result register.
// ----------------------------------------------------------------------------
module ttt_datapath
    import ttt_pkg::*;
#(
    parameter int ENTRIES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_cfg_valid,
    input  logic [AGE_W-1:0]          i_cfg_data,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [KEY_W-1:0]          i_key,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic [AGE_W-1:0]          i_entry_age,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [MOVE_W-1:0]         i_best_move,
    output logic                      o_hit,
    output logic [KEY_W-1:0]          o_found_key,
    output logic [DEPTH_W-1:0]        o_found_depth,
    output logic [AGE_W-1:0]          o_found_age,
    output logic signed [SCORE_W-1:0] o_found_score,
    output logic [MOVE_W-1:0]         o_found_move
);

    localparam int                IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_C = IDX_W'(ENTRIES - 1);

    // Captured request.
    logic [FUNC_W-1:0]  r_func;
    logic [KEY_W-1:0]   r_key;
    logic [DEPTH_W-1:0] r_depth;
    logic [AGE_W-1:0]   r_age;
    logic [SCORE_W-1:0] r_score;
    logic [MOVE_W-1:0]  r_move;

    logic [AGE_W-1:0]   r_age_tol;
    logic [IDX_W-1:0]   r_wipe_cnt;

    t_entry             r_newest_mem [ENTRIES];
    t_entry             r_deep_mem   [ENTRIES];
    t_entry             r_newest_rd;
    t_entry             r_deep_rd;

    logic               r_hit;
    t_entry             r_found;

    logic               idx_done;
    logic [IDX_W-1:0]   idx;
    logic signed [AGE_W:0] gap;
    logic               to_deep;
    logic               is_store;
    logic               newest_we;
    logic               deep_we;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    t_entry             new_entry;
    logic               n_hit;
    t_entry             n_found;

    // Slot index unit, started on every accepted request.
    ttt_mod #(
        .ENTRIES (ENTRIES)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load),
        .i_key   (i_key),
        .o_done  (idx_done),
        .o_idx   (idx)
    );

    // Capture the request fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_depth <= i_search_depth;
            r_age   <= i_entry_age;
            r_score <= i_score;
            r_move  <= i_best_move;
        end
    end

    // Age tolerance register; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_tol <= AGE_TOL_RESET;
        end else if (i_cfg_valid) begin
            r_age_tol <= i_cfg_data;
        end
    end

    // Sweep address, returning to zero after the last slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wipe_cnt <= '0;
        end else if (i_cmd.wipe) begin
            r_wipe_cnt <= (r_wipe_cnt == LAST_C) ? '0 : r_wipe_cnt + 1'b1;
        end
    end

    assign o_sts.wipe_last = (r_wipe_cnt == LAST_C);
    assign o_sts.idx_done  = idx_done;

    // Replacement rule, judged against the newest-way slot. The age gap is
    // exact, so a negative gap always counts as within tolerance.
    assign gap     = $signed({1'b0, r_age}) - $signed({1'b0, r_newest_rd.age});
    assign to_deep = (r_depth <= r_newest_rd.depth) ||
                     (gap <= $signed({1'b0, r_age_tol}));
    assign is_store = i_cmd.commit && (r_func == FUNC_STORE);

    assign new_entry = '{key: r_key, age: r_age, score: r_score,
                         move: r_move, depth: r_depth};

    // Write port shared by the sweep and the store.
    assign newest_we = i_cmd.wipe || (is_store && !to_deep);
    assign deep_we   = i_cmd.wipe || (is_store && to_deep);
    assign wr_addr   = i_cmd.wipe ? r_wipe_cnt : idx;
    assign wr_data   = i_cmd.wipe ? '0 : new_entry;

    // Newest way memory.
    always_ff @(posedge i_clk) begin
        if (newest_we) begin
            r_newest_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.read) begin
            r_newest_rd <= r_newest_mem[idx];
        end
    end

    // Deep way memory.
    always_ff @(posedge i_clk) begin
        if (deep_we) begin
            r_deep_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.read) begin
            r_deep_rd <= r_deep_mem[idx];
        end
    end

    // Lookup result: newest way first, then deep way; zero otherwise.
    always_comb begin
        n_hit   = 1'b0;
        n_found = '0;
        if (r_func == FUNC_LOOKUP) begin
            if (r_newest_rd.key == r_key) begin
                n_hit   = 1'b1;
                n_found = r_newest_rd;
            end else if (r_deep_rd.key == r_key) begin
                n_hit   = 1'b1;
                n_found = r_deep_rd;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_hit   <= n_hit;
            r_found <= n_found;
        end
    end

    assign o_hit         = r_hit;
    assign o_found_key   = r_found.key;
    assign o_found_depth = r_found.depth;
    assign o_found_age   = r_found.age;
    assign o_found_score = r_found.score;
    assign o_found_move  = r_found.move;

endmodule

FILE: hdl/ttt_ctrl.sv
// ----------------------------------------------------------------------------
// ttt_ctrl
// Sequencer for the transposition table: reset and clear sweeps, request capture,
// index wait, memory read, commit and result hand-off.
// ----------------------------------------------------------------------------
module ttt_ctrl
    import ttt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    input  logic              i_out_stall,
    input  t_sts              i_sts,
    output t_cmd              o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_INDEX,
        ST_EVAL,
        ST_HOLD,
        ST_CLEAR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.wipe = 1'b1;
                if (i_sts.wipe_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_CLEAR) ? ST_CLEAR : ST_INDEX;
                end
            end
            ST_INDEX: begin
                if (i_sts.idx_done) begin
                    o_cmd.read = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.commit = 1'b1;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_cmd.wipe = 1'b1;
                if (i_sts.wipe_last) begin
                    n_state = ST_HOLD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid flag follows the result register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/two_way_transposition_table.sv
// ----------------------------------------------------------------------------
// two_way_transposition_table
// Hash-indexed table with a newest way and a deep way, each ENTRIES slots,
// addressed by key modulo ENTRIES. One request gives one result.
//
// After reset the block sweeps both ways to zero with o_in_stall high; the age
// tolerance port is usable throughout. When ENTRIES is not a power of two, a
// lookup or store also waits on the byte-at-a-time key remainder unit. A clear
// writes one slot of each way per cycle through the single write port. One
// request is in flight at a time; the result register lets the next request
// enter while a result is still stalled.
// ----------------------------------------------------------------------------
module two_way_transposition_table
    import ttt_pkg::*;
#(
    parameter int ENTRIES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write channel (age tolerance).
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [AGE_W-1:0]          i_cfg_data,
    // Request channel.
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [KEY_W-1:0]          i_key,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic [AGE_W-1:0]          i_entry_age,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [MOVE_W-1:0]         i_best_move,
    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit,
    output logic [KEY_W-1:0]          o_found_key,
    output logic [DEPTH_W-1:0]        o_found_depth,
    output logic [AGE_W-1:0]          o_found_age,
    output logic signed [SCORE_W-1:0] o_found_score,
    output logic [MOVE_W-1:0]         o_found_move
);

    t_cmd cmd;
    t_sts sts;

    // The register write is taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    ttt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Storage and compare logic.
    ttt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_search_depth (i_search_depth),
        .i_entry_age    (i_entry_age),
        .i_score        (i_score),
        .i_best_move    (i_best_move),
        .o_hit          (o_hit),
        .o_found_key    (o_found_key),
        .o_found_depth  (o_found_depth),
        .o_found_age    (o_found_age),
        .o_found_score  (o_found_score),
        .o_found_move   (o_found_move)
    );

endmodule

FILE: tb/two_way_transposition_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_way_transposition_table_test
// Self-checking bench for the two-way transposition table. A directed opening
// covers the field extremes, both placement rules for a store, hits in either
// way, key zero on a cleared slot, the unused operation and a clear. Random
// traffic then runs under five age tolerance settings. Keys are drawn mostly
// from a few crowded slots so that stores contend for the two ways. Every
// result is compared against a behavioural copy of the table held in a small
// scoreboard class.
// ----------------------------------------------------------------------------
module two_way_transposition_table_test;
    import ttt_pkg::*;

    localparam int TBL_ENTRIES = 4096;
    localparam int SLOT_W = $clog2(TBL_ENTRIES);
    localparam int ITEMS_PER_PHASE = 320;
    localparam int NUM_PHASES = 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // One request as it is presented on the input channel.
    typedef struct {
        logic [FUNC_W-1:0]         func;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
    } t_table_request;

    // One result as it leaves the output channel.
    typedef struct {
        logic                      hit;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
    } t_table_result;

    // Behavioural copy of both ways plus the queue of results still owed.
    class table_scoreboard;
        t_entry           newest_way [TBL_ENTRIES];
        t_entry           deep_way   [TBL_ENTRIES];
        logic [AGE_W-1:0] age_tol;
        t_table_result    due_results[$];
        int errors, lookups, hits, stores, to_newest, to_deep, clears, unused;

        function new();
            wipe();
            age_tol = AGE_TOL_RESET;
        endfunction

        function void wipe();
            foreach (newest_way[i]) begin
                newest_way[i] = '0;
                deep_way[i]   = '0;
            end
        endfunction

        function void set_tolerance(logic [AGE_W-1:0] value);
            age_tol = value;
        endfunction

        // Work out the result of an accepted request and update the table.
        function void note_request(t_table_request r);
            t_table_result res;
            int unsigned   slot;
            int            gap;
            int            tol;
            t_entry        hit_entry;
            t_entry        fresh;
            bit            matched;
            res = '{default: '0};
            slot = 32'(r.key % TBL_ENTRIES);
            matched = 1'b0;
            case (r.func)
                FUNC_LOOKUP: begin
                    lookups++;
                    if (newest_way[slot].key == r.key) begin
                        hit_entry = newest_way[slot];
                        matched = 1'b1;
                    end else if (deep_way[slot].key == r.key) begin
                        hit_entry = deep_way[slot];
                        matched = 1'b1;
                    end
                    if (matched) begin
                        hits++;
                        res.hit   = 1'b1;
                        res.key   = hit_entry.key;
                        res.depth = hit_entry.depth;
                        res.age   = hit_entry.age;
                        res.score = hit_entry.score;
                        res.move  = hit_entry.move;
                    end
                end
                FUNC_STORE: begin
                    stores++;
                    // The gap is taken at full precision, so it never wraps.
                    gap = int'(r.age) - int'(newest_way[slot].age);
                    tol = int'(age_tol);
                    fresh.key   = r.key;
                    fresh.age   = r.age;
                    fresh.score = r.score;
                    fresh.move  = r.move;
                    fresh.depth = r.depth;
                    if (r.depth <= newest_way[slot].depth || gap <= tol) begin
                        deep_way[slot] = fresh;
                        to_deep++;
                    end else begin
                        newest_way[slot] = fresh;
                        to_newest++;
                    end
                end
                FUNC_CLEAR: begin
                    clears++;
                    wipe();
                end
                default: begin
                    unused++;
                end
            endcase
            due_results = {due_results, res};
        endfunction

        function void compare(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        // Compare an accepted result with the oldest one owed.
        function void check_result(t_table_result got);
            t_table_result want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got hit %b key %h",
                         $time, got.hit, got.key);
                return;
            end
            want = due_results.pop_front();
            compare("hit", KEY_W'(want.hit), KEY_W'(got.hit));
            compare("found_key", want.key, got.key);
            compare("found_depth", KEY_W'(want.depth), KEY_W'(got.depth));
            compare("found_age", KEY_W'(want.age), KEY_W'(got.age));
            compare("found_score", KEY_W'(want.score), KEY_W'(got.score));
            compare("found_move", KEY_W'(want.move), KEY_W'(got.move));
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [AGE_W-1:0]          i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [FUNC_W-1:0]         i_func = '0;
    logic [KEY_W-1:0]          i_key = '0;
    logic [DEPTH_W-1:0]        i_search_depth = '0;
    logic [AGE_W-1:0]          i_entry_age = '0;
    logic signed [SCORE_W-1:0] i_score = '0;
    logic [MOVE_W-1:0]         i_best_move = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_hit;
    logic [KEY_W-1:0]          o_found_key;
    logic [DEPTH_W-1:0]        o_found_depth;
    logic [AGE_W-1:0]          o_found_age;
    logic signed [SCORE_W-1:0] o_found_score;
    logic [MOVE_W-1:0]         o_found_move;

    table_scoreboard  sb;
    t_table_result    observed;
    logic [KEY_W-1:0] known_keys[$];
    int               burst_left = 0;
    int               gap_max = 0;
    int               stall_pct = 0;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    two_way_transposition_table #(
        .ENTRIES(TBL_ENTRIES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_search_depth (i_search_depth),
        .i_entry_age    (i_entry_age),
        .i_score        (i_score),
        .i_best_move    (i_best_move),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_found_key    (o_found_key),
        .o_found_depth  (o_found_depth),
        .o_found_age    (o_found_age),
        .o_found_score  (o_found_score),
        .o_found_move   (o_found_move)
    );

    // Free-running clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result monitor, followed by the receiver's own stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            observed.hit   = o_hit;
            observed.key   = o_found_key;
            observed.depth = o_found_depth;
            observed.age   = o_found_age;
            observed.score = o_found_score;
            observed.move  = o_found_move;
            sb.check_result(observed);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Count cycles in which no handshake of any kind completes.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("two_way_transposition_table verification failed");
        $finish;
    end

    function automatic t_table_request make_request(logic [FUNC_W-1:0] func,
            logic [KEY_W-1:0] key, logic [DEPTH_W-1:0] depth, logic [AGE_W-1:0] age,
            logic signed [SCORE_W-1:0] score, logic [MOVE_W-1:0] move);
        t_table_request r;
        r.func  = func;
        r.key   = key;
        r.depth = depth;
        r.age   = age;
        r.score = score;
        r.move  = move;
        return r;
    endfunction

    // Keys packed into a handful of slots, with a small set of tags.
    function automatic logic [KEY_W-1:0] crowded_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            k[KEY_W-1:SLOT_W] = (KEY_W - SLOT_W)'($urandom_range(0, 3));
        end
        case ($urandom_range(0, 4))
            0: k[SLOT_W-1:0] = '1;
            4: ;
            default: k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 5));
        endcase
        return k;
    endfunction

    // Random request; store ages and depths are often placed around the
    // resident newest entry so that both placement rules sit near their edge.
    function automatic t_table_request random_request();
        t_table_request r;
        int unsigned    pick;
        int unsigned    slot;
        t_entry         resident;
        pick    = $urandom_range(0, 999);
        r.key   = {$urandom, $urandom};
        r.depth = DEPTH_W'($urandom);
        r.age   = AGE_W'($urandom);
        r.score = $urandom;
        r.move  = MOVE_W'($urandom);
        if (pick < 3) begin
            r.func = FUNC_CLEAR;
        end else if (pick < 60) begin
            r.func = FUNC_UNUSED;
        end else if (pick < 520) begin
            r.func = FUNC_LOOKUP;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if (known_keys.size() > 0) begin
                        r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    end
                end
                6, 7: r.key = crowded_key();
                8: r.key = '0;
                default: ;
            endcase
        end else begin
            r.func = FUNC_STORE;
            if ($urandom_range(0, 4) != 0) begin
                r.key = crowded_key();
            end
            slot = 32'(r.key % TBL_ENTRIES);
            resident = sb.newest_way[slot];
            case ($urandom_range(0, 3))
                1: r.age = resident.age + AGE_W'($urandom_range(0, 8)) - AGE_W'(3);
                2: r.age = resident.age + sb.age_tol + AGE_W'($urandom_range(0, 2)) - AGE_W'(1);
                3: r.age = resident.age - AGE_W'($urandom_range(0, 6));
                default: ;
            endcase
            if ($urandom_range(0, 1) != 0) begin
                r.depth = resident.depth + DEPTH_W'($urandom_range(0, 2)) - DEPTH_W'(1);
            end
            known_keys = {known_keys, r.key};
            if (known_keys.size() > 64) begin
                void'(known_keys.pop_front());
            end
        end
        return r;
    endfunction

    // Present one request, in bursts separated by random gaps.
    task automatic send_request(t_table_request r);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_func         <= r.func;
        i_key          <= r.key;
        i_search_depth <= r.depth;
        i_entry_age    <= r.age;
        i_score        <= r.score;
        i_best_move    <= r.move;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_request(r);
    endtask

    // Stop sending and wait until every owed result has been taken.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.due_results.size() != 0);
    endtask

    task automatic write_tolerance(logic [AGE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        sb.set_tolerance(value);
    endtask

    initial begin
        logic [AGE_W-1:0] phase_tol[NUM_PHASES];
        sb = new();
        phase_tol[0] = AGE_TOL_RESET;
        phase_tol[1] = '0;
        phase_tol[2] = '1;
        phase_tol[3] = AGE_W'($urandom_range(5, 65534));
        phase_tol[4] = AGE_W'(1);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening, under the reset tolerance.
        gap_max = 2;
        stall_pct = 15;
        // Key zero finds the cleared slot; an arbitrary key misses.
        send_request(make_request(FUNC_LOOKUP, '0, '0, '0, '0, '0));
        send_request(make_request(FUNC_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, '0, '0, '0));
        send_request(make_request(FUNC_UNUSED, '1, '1, '1, '1, '1));
        // Largest values land in the newest way; smallest then go deep.
        send_request(make_request(FUNC_STORE, '1, '1, '1, 32'sh7FFF_FFFF, '1));
        send_request(make_request(FUNC_LOOKUP, '1, '0, '0, '0, '0));
        send_request(make_request(FUNC_STORE, 64'h1FFF, '0, '0, 32'sh8000_0000, '0));
        send_request(make_request(FUNC_LOOKUP, 64'h1FFF, '0, '0, '0, '0));
        send_request(make_request(FUNC_STORE, 64'h2FFF, 8'd1, '1, 32'sd1, 16'd1));
        // Age gap just over, at, and below the tolerance, and equal depth.
        send_request(make_request(FUNC_STORE, 64'hA000_0000_0000_0005, 8'd10, 16'd10,
                                  32'sd100, 16'h0A0A));
        send_request(make_request(FUNC_STORE, 64'hB000_0000_0000_0005, 8'd20, 16'd14,
                                  -32'sd200, 16'h0B0B));
        send_request(make_request(FUNC_STORE, 64'hC000_0000_0000_0005, 8'd20, 16'd15,
                                  32'sd300, 16'h0C0C));
        send_request(make_request(FUNC_STORE, 64'hD000_0000_0000_0005, 8'd30, 16'd3,
                                  -32'sd400, 16'h0D0D));
        send_request(make_request(FUNC_STORE, 64'hE000_0000_0000_0005, 8'd20, 16'd200,
                                  32'sd500, 16'h0E0E));
        send_request(make_request(FUNC_LOOKUP, 64'hC000_0000_0000_0005, '0, '0, '0, '0));
        send_request(make_request(FUNC_LOOKUP, 64'hE000_0000_0000_0005, '0, '0, '0, '0));
        send_request(make_request(FUNC_LOOKUP, 64'hA000_0000_0000_0005, '0, '0, '0, '0));
        // Clear, then the table must look as it did after reset.
        send_request(make_request(FUNC_CLEAR, '0, '0, '0, '0, '0));
        send_request(make_request(FUNC_LOOKUP, '1, '0, '0, '0, '0));
        send_request(make_request(FUNC_LOOKUP, '0, '0, '0, '0, '0));
        send_request(make_request(FUNC_STORE, '0, 8'd7, 16'd100, -32'sd5, 16'd1234));
        send_request(make_request(FUNC_LOOKUP, '0, '0, '0, '0, '0));
        send_request(make_request(FUNC_LOOKUP, 64'h1000, '0, '0, '0, '0));
        send_request(make_request(FUNC_STORE, 64'h5555_5555_5555_5555, 8'd1, '0,
                                  32'sh5555_5555, 16'h5555));
        send_request(make_request(FUNC_LOOKUP, 64'h5555_5555_5555_5555, '0, '0, '0, '0));

        // Random traffic, one tolerance setting and idling profile per phase.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_results();
            if (ph != 0) begin
                write_tolerance(phase_tol[ph]);
            end
            case (ph)
                0: begin gap_max = 0; stall_pct = 0;  end
                1: begin gap_max = 3; stall_pct = 20; end
                2: begin gap_max = 8; stall_pct = 50; end
                3: begin gap_max = 2; stall_pct = 5;  end
                default: begin gap_max = 5; stall_pct = 35; end
            endcase
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end

        wait_for_results();
        repeat (16) @(posedge i_clk);
        $display("Ran %0d lookups (%0d hits), %0d stores (%0d newest, %0d deep),",
                 sb.lookups, sb.hits, sb.stores, sb.to_newest, sb.to_deep);
        $display("%0d clears and %0d unused codes, age tolerance 4, 0, 65535, %0d and 1.",
                 sb.clears, sb.unused, phase_tol[3]);
        if (sb.errors == 0) begin
            $display("two_way_transposition_table verification clean");
        end else begin
            $display("two_way_transposition_table verification failed");
        end
        $finish;
    end

endmodule
